// ===== hw/rtl/phc_pkg.sv =====
// Package for the half-plane polygon clipper: field widths, register
// indexes, the count limit and the normal clamp. No dependencies.
`timescale 1ns / 1ps

package phc_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int COORD_W      = 32;
  localparam int NORM_W       = 18;
  localparam int OFFSET_W     = 32;
  localparam int DIST_W       = 50;
  localparam int DEN_W        = DIST_W + 1;
  localparam int MUL_A_W      = COORD_W + 2;
  localparam int MUL_B_W      = NORM_W;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int COUNT_W      = 12;
  localparam int MAX_VERTICES = 1024;
  localparam int COUNT_CAP    = ((2 * MAX_VERTICES) > 4095) ? 4095 : (2 * MAX_VERTICES);
  localparam int DIV_CNT_W    = $clog2(FRAC_BITS);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [DIST_W-1:0]  dist_t;
  typedef logic [DIST_W-1:0]         mag_t;
  typedef logic [DEN_W-1:0]          den_t;
  typedef logic [FRAC_BITS-1:0]      frac_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam norm_t NORM_ONE     = norm_t'(1 << FRAC_BITS);
  localparam norm_t NORM_NEG_ONE = norm_t'(-(1 << FRAC_BITS));

  function automatic norm_t clamp_normal(input norm_t v);
    norm_t r;
    if (v > NORM_ONE) begin
      r = NORM_ONE;
    end else if (v < NORM_NEG_ONE) begin
      r = NORM_NEG_ONE;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/phc_stream_if.sv =====
// Valid/ready stream interfaces for the clipper: vertex beats in, point
// beats out. Depends on phc_pkg.
`timescale 1ns / 1ps

interface phc_vertex_if import phc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

interface phc_point_if import phc_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   point_valid;
  logic   is_crossing;
  logic   last_result;
  count_t vertex_count;

  modport source (output valid, output point_x, output point_y, output point_valid,
                  output is_crossing, output last_result, output vertex_count,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_valid,
                input is_crossing, input last_result, input vertex_count,
                output ready);
endinterface

// ===== hw/rtl/polygon_halfplane_clip_top.sv =====
// Half-plane polygon clipper, one clipping stage: sequencer, shared multiplier
// and result register. Depends on phc_pkg, phc_stream_if and phc_frac_div.
//
// Vertices arrive as beats on the vertex channel, one polygon after another,
// the final vertex marked by last_vertex. Each vertex gives zero to four point
// beats: the start of each edge if it lies strictly inside, then the crossing
// point when the edge ends lie strictly on opposite sides. The closing edge is
// handled with the final vertex; the last beat of a polygon carries
// last_result and the vertex count, and an empty final vertex gives one end
// beat with point_valid low.
// The block takes one vertex at a time and is not ready while it works on it.
// A vertex takes longer for each inside vertex it emits and longer still for each
// crossing; the serial divider that forms the crossing fraction and the
// single shared multiplier set that time.
// Results sit in one output register, so the next result waits while the
// receiver stalls, and the sequencer holds until that register is free.
// Synchronous reset clears the polygon state and loads the default plane
// (normal pointing along y, zero offset). Registers on the configuration port are
// to be written by the user only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

module polygon_halfplane_clip_top import phc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  phc_vertex_if.sink            vertex,
  phc_point_if.source           point,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MULX   = 4'd1;
  localparam logic [3:0] S_MULY   = 4'd2;
  localparam logic [3:0] S_DIST   = 4'd3;
  localparam logic [3:0] S_MASK   = 4'd4;
  localparam logic [3:0] S_STEP   = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_MULCX  = 4'd7;
  localparam logic [3:0] S_MULCY  = 4'd8;
  localparam logic [3:0] S_ADDY   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;
  localparam logic [3:0] S_FINISH = 4'd11;

  logic [3:0] state;
  logic [1:0] step;
  logic [3:0] mask;

  norm_t  normal_x;
  norm_t  normal_y;
  coord_t plane_offset;

  coord_t cur_x;
  coord_t cur_y;
  logic   cur_last;
  dist_t  cur_d;
  coord_t first_x;
  coord_t first_y;
  dist_t  first_d;
  coord_t previous_x;
  coord_t previous_y;
  dist_t  previous_d;
  logic   have_first;
  count_t emitted_count;
  count_t count_next;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  dist_t                     acc;

  coord_t px;
  coord_t py;
  logic   em_cross;

  coord_t ax;
  coord_t ay;
  coord_t bx;
  coord_t by;
  dist_t  da;
  dist_t  db;
  mag_t   ma;
  mag_t   mb;
  den_t   den;
  dist_t  first_d_eff;
  logic   more_after;

  logic  div_start;
  logic  div_done;
  frac_t div_quot;

  logic   out_valid;
  coord_t out_x;
  coord_t out_y;
  logic   out_pv;
  logic   out_cross;
  logic   out_last;
  count_t out_count;
  logic   slot_free;
  logic   out_load;

  assign vertex.ready       = (state == S_IDLE);
  assign point.valid        = out_valid;
  assign point.point_x      = out_x;
  assign point.point_y      = out_y;
  assign point.point_valid  = out_pv;
  assign point.is_crossing  = out_cross;
  assign point.last_result  = out_last;
  assign point.vertex_count = out_count;

  assign slot_free = !out_valid || point.ready;
  assign out_load  = slot_free &&
                     ((state == S_EMIT) || ((state == S_FINISH) && cur_last && (mask == '0)));

  function automatic logic opposite(input dist_t p, input dist_t q);
    logic p_neg;
    logic q_neg;
    logic p_pos;
    logic q_pos;
    p_neg = p[DIST_W-1];
    q_neg = q[DIST_W-1];
    p_pos = !p_neg && (p != '0);
    q_pos = !q_neg && (q != '0);
    return (p_neg && q_pos) || (p_pos && q_neg);
  endfunction

  function automatic mag_t magnitude(input dist_t v);
    return v[DIST_W-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  // Edge zero runs from the previous vertex to this one, edge one closes the polygon.
  assign ax = step[1] ? cur_x : previous_x;
  assign ay = step[1] ? cur_y : previous_y;
  assign bx = step[1] ? first_x : cur_x;
  assign by = step[1] ? first_y : cur_y;
  assign da = step[1] ? cur_d : previous_d;
  assign db = step[1] ? first_d : cur_d;
  assign ma = magnitude(da);
  assign mb = magnitude(db);
  assign den = DEN_W'(ma) + DEN_W'(mb);
  assign first_d_eff = have_first ? first_d : cur_d;

  assign count_next = (emitted_count < count_t'(COUNT_CAP)) ? emitted_count + 1'b1
                                                            : emitted_count;

  always_comb begin
    unique case (step)
      2'd0: more_after = mask[3:1] != '0;
      2'd1: more_after = mask[3:2] != '0;
      2'd2: more_after = mask[3];
      2'd3: more_after = 1'b0;
      default: more_after = 1'b0;
    endcase
  end

  always_comb begin
    unique case (state)
      S_MULY: begin
        mul_a = MUL_A_W'(cur_y);
        mul_b = clamp_normal(normal_y);
      end
      S_MULCX: begin
        mul_a = {{2{bx[COORD_W-1]}}, bx} - {{2{ax[COORD_W-1]}}, ax};
        mul_b = signed'({2'b00, div_quot});
      end
      S_MULCY: begin
        mul_a = {{2{by[COORD_W-1]}}, by} - {{2{ay[COORD_W-1]}}, ay};
        mul_b = signed'({2'b00, div_quot});
      end
      default: begin
        mul_a = MUL_A_W'(cur_x);
        mul_b = clamp_normal(normal_x);
      end
    endcase
  end

  assign div_start = (state == S_STEP) && mask[step] && step[0];

  phc_frac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ma),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_x     <= '0;
      normal_y     <= NORM_ONE;
      plane_offset <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NORMAL_X:     normal_x     <= norm_t'(cfg_data[NORM_W-1:0]);
        REG_NORMAL_Y:     normal_y     <= norm_t'(cfg_data[NORM_W-1:0]);
        REG_PLANE_OFFSET: plane_offset <= coord_t'(cfg_data[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= '0;
      mask          <= '0;
      have_first    <= 1'b0;
      emitted_count <= '0;
      out_valid     <= 1'b0;
      first_x       <= '0;
      first_y       <= '0;
      first_d       <= '0;
      previous_x    <= '0;
      previous_y    <= '0;
      previous_d    <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && point.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (vertex.valid) begin
            cur_x    <= vertex.vertex_x;
            cur_y    <= vertex.vertex_y;
            cur_last <= vertex.last_vertex;
            state    <= S_MULX;
          end
        end
        S_MULX: begin
          state <= S_MULY;
        end
        S_MULY: begin
          acc   <= dist_t'(prod) - dist_t'(signed'({plane_offset, {FRAC_BITS{1'b0}}}));
          state <= S_DIST;
        end
        S_DIST: begin
          cur_d <= acc + dist_t'(prod);
          state <= S_MASK;
        end
        S_MASK: begin
          mask[0] <= have_first && previous_d[DIST_W-1];
          mask[1] <= have_first && opposite(previous_d, cur_d);
          mask[2] <= cur_last && cur_d[DIST_W-1];
          mask[3] <= cur_last && opposite(cur_d, first_d_eff);
          if (!have_first) begin
            first_x <= cur_x;
            first_y <= cur_y;
            first_d <= cur_d;
          end
          step  <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          if (mask[step]) begin
            if (step[0]) begin
              state <= S_DIV;
            end else begin
              px       <= ax;
              py       <= ay;
              em_cross <= 1'b0;
              state    <= S_EMIT;
            end
          end else if (step == 2'd3) begin
            state <= S_FINISH;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MULCX;
          end
        end
        S_MULCX: begin
          state <= S_MULCY;
        end
        S_MULCY: begin
          px    <= ax + coord_t'(prod[COORD_W+FRAC_BITS-1:FRAC_BITS]);
          state <= S_ADDY;
        end
        S_ADDY: begin
          py       <= ay + coord_t'(prod[COORD_W+FRAC_BITS-1:FRAC_BITS]);
          em_cross <= 1'b1;
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_x         <= px;
            out_y         <= py;
            out_pv        <= 1'b1;
            out_cross     <= em_cross;
            out_last      <= cur_last && !more_after;
            out_count     <= count_next;
            emitted_count <= count_next;
            if (step == 2'd3) begin
              state <= S_FINISH;
            end else begin
              step  <= step + 1'b1;
              state <= S_STEP;
            end
          end
        end
        S_FINISH: begin
          if (!(cur_last && mask == '0) || slot_free) begin
            if (cur_last && mask == '0) begin
              out_x     <= '0;
              out_y     <= '0;
              out_pv    <= 1'b0;
              out_cross <= 1'b0;
              out_last  <= 1'b1;
              out_count <= emitted_count;
            end
            if (cur_last) begin
              have_first    <= 1'b0;
              emitted_count <= '0;
            end else begin
              have_first <= 1'b1;
              previous_x <= cur_x;
              previous_y <= cur_y;
              previous_d <= cur_d;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/phc_frac_div.sv =====
// Restoring divider, one quotient bit per cycle, giving floor(num * 2^FRAC_BITS / den)
// for num < den. Depends on phc_pkg.
`timescale 1ns / 1ps

module phc_frac_div import phc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  mag_t  num,
  input  den_t  den,
  output logic  done,
  output frac_t quot
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  den_t                 rem;
  den_t                 den_q;
  logic [DEN_W:0]       rem_shift;
  logic                 fits;

  assign rem_shift = {rem, 1'b0};
  assign fits      = rem_shift >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(FRAC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_q <= den;
      quot  <= '0;
    end else if (busy) begin
      if (fits) begin
        rem  <= DEN_W'(rem_shift - {1'b0, den_q});
        quot <= {quot[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_shift[DEN_W-1:0];
        quot <= {quot[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

endmodule
